@@ design/qmm_pkg.sv @@
// Shared types, constants and register indexes for the quad motor mixer.
// No dependencies; every design file imports this package.
package qmm_pkg;

  localparam int unsigned NUM_MOTORS = 4;
  localparam int unsigned NUM_AXES   = 4;

  localparam int unsigned CMD_W   = 16;                    // Q7.8 command
  localparam int unsigned COEF_W  = 16;                    // Q2.13 coefficient
  localparam int unsigned PROD_W  = CMD_W + COEF_W;        // Q10.21 product
  localparam int unsigned SUM_W   = PROD_W + 2;            // four products
  localparam int unsigned FRAC_DROP = 9;                   // Q12.21 -> Q.12
  localparam int unsigned BIAS_W  = 14;
  localparam int unsigned RAW_W   = SUM_W - FRAC_DROP + 1; // shifted sum plus bias
  localparam int unsigned THR_W   = 13;                    // 0..4096
  localparam int unsigned THR_ONE = 4096;
  localparam int unsigned THR_FRAC = 12;
  localparam int unsigned OFF_W   = 9;
  localparam int unsigned OUT_W   = 12;

  // Duty scaling; fixed by the output field width of the port.
  localparam int unsigned PWM_BITS  = 12;
  localparam int unsigned DUTY_W    = PWM_BITS + 2;
  localparam int unsigned DUTY_MAX  = (1 << PWM_BITS) - 1;
  localparam int unsigned DUTY_BASE = (1 << (PWM_BITS - 1)) - 1;
  localparam int unsigned TERM_W    = THR_W + PWM_BITS - 1;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_ADDR_W-1:0] IDX_MIX_ROW_0     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] IDX_MIX_ROW_1     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] IDX_MIX_ROW_2     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] IDX_MIX_ROW_3     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] IDX_THROTTLE_BIAS = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] IDX_MOTOR_OFFSETS = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] IDX_FORCE_DISARM  = 3'd6;

  localparam logic signed [BIAS_W-1:0] BIAS_RESET = 14'sd205;

  typedef struct packed {
    logic signed [CMD_W-1:0] roll_torque;
    logic signed [CMD_W-1:0] pitch_torque;
    logic signed [CMD_W-1:0] yaw_torque;
    logic signed [CMD_W-1:0] total_thrust;
    logic                    armed;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] pwm_motor_1;
    logic [OUT_W-1:0] pwm_motor_2;
    logic [OUT_W-1:0] pwm_motor_3;
    logic [OUT_W-1:0] pwm_motor_4;
  } out_t;

  typedef struct packed {
    logic [NUM_MOTORS-1:0][CFG_DATA_W-1:0] mix_row;
    logic signed [BIAS_W-1:0]              throttle_bias;
    logic [NUM_MOTORS-1:0][OFF_W-1:0]      motor_offsets;
    logic                                  force_disarm;
  } cfg_t;

  // Stage 1 -> 2: raw products, motor-major
  typedef struct packed {
    logic                                          live;
    logic [NUM_MOTORS-1:0][NUM_AXES-1:0][PROD_W-1:0] prod;
  } prod_t;

  // Stage 2 -> 3: unclamped Q.12 throttle per motor
  typedef struct packed {
    logic                             live;
    logic [NUM_MOTORS-1:0][RAW_W-1:0] thr_raw;
  } raw_t;

endpackage

@@ design/qmm_cfg.sv @@
// Configuration register file for the quad motor mixer.
// Depends on qmm_pkg.
module qmm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [qmm_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [qmm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output qmm_pkg::cfg_t                       cfg_o
);
  import qmm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mix_row       <= '0;
      cfg_q.throttle_bias <= BIAS_RESET;
      cfg_q.motor_offsets <= '0;
      cfg_q.force_disarm  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        IDX_MIX_ROW_0, IDX_MIX_ROW_1, IDX_MIX_ROW_2, IDX_MIX_ROW_3: begin
          cfg_q.mix_row[cfg_addr_i[1:0]] <= cfg_wdata_i;
        end
        IDX_THROTTLE_BIAS: begin
          cfg_q.throttle_bias <= cfg_wdata_i[BIAS_W-1:0];
        end
        IDX_MOTOR_OFFSETS: begin
          cfg_q.motor_offsets <= cfg_wdata_i[NUM_MOTORS*OFF_W-1:0];
        end
        IDX_FORCE_DISARM: begin
          cfg_q.force_disarm <= cfg_wdata_i[0];
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/qmm_mult.sv @@
// Stage 1: sixteen signed 16x16 products of coefficients and commands.
// Depends on qmm_pkg.
module qmm_mult (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qmm_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  qmm_pkg::in_t   data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output qmm_pkg::prod_t data_o
);
  import qmm_pkg::*;

  logic  valid_q;
  prod_t data_q, data_d;
  logic signed [CMD_W-1:0] vec [NUM_AXES];

  assign vec[0] = data_i.roll_torque;
  assign vec[1] = data_i.pitch_torque;
  assign vec[2] = data_i.yaw_torque;
  assign vec[3] = data_i.total_thrust;

  always_comb begin
    data_d.live = data_i.armed & ~cfg_i.force_disarm;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        data_d.prod[m][j] = $signed(cfg_i.mix_row[m][COEF_W*j +: COEF_W]) * vec[j];
      end
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/qmm_sum.sv @@
// Stage 2: add the four products per motor, floor to Q.12 and add the bias.
// Depends on qmm_pkg.
module qmm_sum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qmm_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  output logic           ready_o,
  input  qmm_pkg::prod_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output qmm_pkg::raw_t  data_o
);
  import qmm_pkg::*;

  logic valid_q;
  raw_t data_q, data_d;
  logic signed [SUM_W-1:0] sum [NUM_MOTORS];

  always_comb begin
    data_d.live = data_i.live;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      sum[m] = SUM_W'($signed(data_i.prod[m][0])) + SUM_W'($signed(data_i.prod[m][1]))
             + SUM_W'($signed(data_i.prod[m][2])) + SUM_W'($signed(data_i.prod[m][3]));
      // arithmetic shift floors toward minus infinity
      data_d.thr_raw[m] = RAW_W'(sum[m] >>> FRAC_DROP) + RAW_W'(cfg_i.throttle_bias);
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/qmm_duty.sv @@
// Stage 3: clamp the throttle, gate on arming, form the saturated PWM duty.
// Depends on qmm_pkg.
module qmm_duty (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  qmm_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  qmm_pkg::raw_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output qmm_pkg::out_t data_o
);
  import qmm_pkg::*;

  logic valid_q;
  out_t data_q, data_d;
  logic [THR_W-1:0]  thr  [NUM_MOTORS];
  logic [TERM_W-1:0] term [NUM_MOTORS];
  logic [DUTY_W-1:0] duty [NUM_MOTORS];
  logic [OUT_W-1:0]  pwm  [NUM_MOTORS];

  always_comb begin
    for (int m = 0; m < NUM_MOTORS; m++) begin
      if (!data_i.live || $signed(data_i.thr_raw[m]) < 0) begin
        thr[m] = '0;
      end else if ($signed(data_i.thr_raw[m]) > $signed(RAW_W'(THR_ONE))) begin
        thr[m] = THR_W'(THR_ONE);
      end else begin
        thr[m] = data_i.thr_raw[m][THR_W-1:0];
      end
      term[m] = (TERM_W'(thr[m]) << (PWM_BITS - 1)) >> THR_FRAC;
      duty[m] = DUTY_W'(DUTY_BASE) + DUTY_W'(term[m]) + DUTY_W'(cfg_i.motor_offsets[m]);
      if (duty[m] > DUTY_W'(DUTY_MAX)) begin
        duty[m] = DUTY_W'(DUTY_MAX);
      end
      pwm[m] = OUT_W'(duty[m]);
    end
    data_d.pwm_motor_1 = pwm[0];
    data_d.pwm_motor_2 = pwm[1];
    data_d.pwm_motor_3 = pwm[2];
    data_d.pwm_motor_4 = pwm[3];
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/quad_motor_mixer_pwm_top.sv @@
// Quad motor mixer with PWM duty output: three-stage pipeline.
// Each beat passes the registers of qmm_mult, qmm_sum and qmm_duty in turn.
// Throughput: one beat per cycle while the output is not stalled; each stage holds its own valid bit and
// takes a new beat whenever it is empty or its downstream neighbour moves.
// Reset: valid bits cleared, mixing rows and offsets zero, bias 205, force-disarm clear.
// Depends on qmm_pkg, qmm_cfg, qmm_mult, qmm_sum and qmm_duty.
module quad_motor_mixer_pwm_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  qmm_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output qmm_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [qmm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [qmm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import qmm_pkg::*;

  cfg_t  cfg;
  prod_t s1_data;
  raw_t  s2_data;
  logic  s1_valid, s1_ready;
  logic  s2_valid, s2_ready;

  // Register file; the user must write it only while the pipeline is empty,
  // which the block does not enforce, so every stage may read it directly.
  qmm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Stage 1: all sixteen products in parallel, arming folded to one bit.
  qmm_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Stage 2: per-motor dot-product sum, floor to Q.12, add bias.
  qmm_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Stage 3: clamp, disarm gating, duty and saturation; its register is the
  // output register, so a stalled beat here does not block earlier stages
  // from filling up behind it.
  qmm_duty u_duty (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // Input back-pressure only arises when every stage holds a beat and the
  // output is stalled.
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid && s2_valid && out_valid_o && !out_ready_i))
    else $error("input stalled while the pipeline has a free stage");

  // A beat held in stage 2 under back-pressure must neither vanish nor change.
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid && !s2_ready) |=> (s2_valid && $stable(s2_data)))
    else $error("stage 2 beat lost or altered during a stall");

  // The throttle term and offset are never negative, so no duty drops below
  // the idle base.
  a_duty_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pwm_motor_1 >= OUT_W'(DUTY_BASE)
                  && out_data_o.pwm_motor_2 >= OUT_W'(DUTY_BASE)
                  && out_data_o.pwm_motor_3 >= OUT_W'(DUTY_BASE)
                  && out_data_o.pwm_motor_4 >= OUT_W'(DUTY_BASE)))
    else $error("duty below idle base");

endmodule

@@ dv/quad_motor_mixer_pwm_top_tb.sv @@
// Self-checking testbench for quad_motor_mixer_pwm_top: a directed table, then
// randomised command beats over several register settings, checked by a duty predictor.
// Depends on qmm_pkg and the mixer RTL only.
`timescale 1ns / 1ps

module quad_motor_mixer_pwm_top_tb;
  import qmm_pkg::*;

  localparam int unsigned PIPE_LAT = 3;  // input beat to output beat
  localparam int unsigned IDLE_PCT = 38;
  localparam int unsigned NUM_PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 250;

  // CFG_ADDR_W leaves one index that maps to no register
  localparam logic [CFG_ADDR_W-1:0] IDX_SPARE = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_CMD} row_kind_e;
  typedef enum int {SET_CEIL, SET_FLOOR, SET_KILL, SET_WILD, SET_QUAD} set_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_ADDR_W-1:0]  idx;
    logic [CFG_DATA_W-1:0]  data;
    in_t                    cmd;
    bit                     pinned;
    logic [OUT_W-1:0]       duty;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Predictor's copy of the register file, at reset values
  logic [CFG_DATA_W-1:0]      mix_coef [NUM_MOTORS] = '{default: '0};
  logic signed [BIAS_W-1:0]   bias_q12 = BIAS_RESET;
  logic [NUM_MOTORS*OFF_W-1:0] trim_bits = '0;
  logic                        disarm_sw = 1'b0;

  out_t duty_expect [$];
  row_t plan [$];

  // Directed rows with a typed-in duty push it instead of the prediction
  bit               pin_use = 1'b0;
  logic [OUT_W-1:0] pin_duty = '0;

  bit gap_free   = 1'b0;  // sender never idles while set
  bit stall_free = 1'b0;  // receiver never stalls while set

  int unsigned fail_count   = 0;
  int unsigned cmds_taken   = 0;
  int unsigned duty_checked = 0;
  int unsigned settings_run = 0;

  int corner_vals [5] = '{-32768, 32767, 0, -1, 1};

  quad_motor_mixer_pwm_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("quad_motor_mixer_pwm_top_tb NOT OK");
    $finish;
  end

  // Duty of all four motors for one command beat under the current settings.
  // The Q12.21 sum drops nine fraction bits by floor, so an arithmetic shift.
  function automatic out_t mix_predict(in_t cmd);
    longint axis [NUM_AXES];
    longint acc;
    longint thr;
    longint duty;
    logic [NUM_MOTORS-1:0][OUT_W-1:0] lanes;
    out_t res;
    axis[0] = longint'(cmd.roll_torque);
    axis[1] = longint'(cmd.pitch_torque);
    axis[2] = longint'(cmd.yaw_torque);
    axis[3] = longint'(cmd.total_thrust);
    for (int m = 0; m < NUM_MOTORS; m++) begin
      thr = 0;
      if (cmd.armed && !disarm_sw) begin
        acc = 0;
        for (int j = 0; j < NUM_AXES; j++) begin
          acc += longint'($signed(mix_coef[m][16*j +: 16])) * axis[j];
        end
        thr = (acc >>> FRAC_DROP) + longint'(bias_q12);
        // clamp, never wrap
        if (thr < 0) begin
          thr = 0;
        end else if (thr > longint'(THR_ONE)) begin
          thr = longint'(THR_ONE);
        end
      end
      duty = longint'(DUTY_BASE) + ((thr << (PWM_BITS - 1)) >>> THR_FRAC)
             + longint'(trim_bits[OFF_W*m +: OFF_W]);
      if (duty > longint'(DUTY_MAX)) begin
        duty = longint'(DUTY_MAX);
      end
      // out_t carries motor 1 in its top lane
      lanes[NUM_MOTORS-1-m] = duty[OUT_W-1:0];
    end
    res = lanes;
    return res;
  endfunction

  // Receiver: stall at random unless a stall-free stretch is running
  always @(negedge clk_i) begin
    out_ready_i <= stall_free || ($urandom_range(99) >= IDLE_PCT);
  end

  // Capture accepted commands and check every accepted duty beat
  always @(posedge clk_i) begin : watch
    out_t want;
    logic [NUM_MOTORS-1:0][OUT_W-1:0] w_l;
    logic [NUM_MOTORS-1:0][OUT_W-1:0] g_l;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        cmds_taken++;
        if (pin_use) begin
          duty_expect.push_back({NUM_MOTORS{pin_duty}});
        end else begin
          duty_expect.push_back(mix_predict(in_data_i));
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (duty_expect.size() == 0) begin
          $error("duty beat with nothing expected: %h", out_data_o);
          fail_count++;
        end else begin
          want = duty_expect.pop_front();
          w_l = want;
          g_l = out_data_o;
          duty_checked++;
          for (int m = 0; m < NUM_MOTORS; m++) begin
            if (w_l[NUM_MOTORS-1-m] !== g_l[NUM_MOTORS-1-m]) begin
              $error("pwm_motor_%0d: expected %0d, got %0d", m + 1,
                     w_l[NUM_MOTORS-1-m], g_l[NUM_MOTORS-1-m]);
              fail_count++;
            end
          end
        end
      end
    end
  end

  // Write one register and mirror it into the predictor; call at a falling edge
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = data;
    case (idx)
      IDX_MIX_ROW_0, IDX_MIX_ROW_1, IDX_MIX_ROW_2, IDX_MIX_ROW_3: begin
        mix_coef[idx[1:0]] = data;
      end
      IDX_THROTTLE_BIAS: begin
        bias_q12 = data[BIAS_W-1:0];
      end
      IDX_MOTOR_OFFSETS: begin
        trim_bits = data[NUM_MOTORS*OFF_W-1:0];
      end
      IDX_FORCE_DISARM: begin
        disarm_sw = data[0];
      end
      default: ;  // unknown index: nothing changes
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Present one command beat, idling first at random; return at the falling
  // edge after acceptance with valid still high
  task automatic send_cmd(input in_t cmd, input bit pinned, input logic [OUT_W-1:0] duty);
    if (!gap_free) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    in_data_i  = cmd;
    pin_use    = pinned;
    pin_duty   = duty;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every expected beat, then let the pipe settle
  task automatic drain_pipe();
    in_valid_i = 1'b0;
    while (duty_expect.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 2) @(negedge clk_i);
  endtask

  task automatic add_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '{kind: ROW_WRITE, idx: idx, data: data, cmd: '0, pinned: 1'b0, duty: '0};
    plan.push_back(r);
  endtask

  // pin < 0: no typed-in duty, the predictor decides
  task automatic add_cmd(input int rl, input int pt, input int yw, input int th,
                         input bit armed, input int pin);
    row_t r;
    r = '{kind: ROW_CMD, idx: '0, data: '0, cmd: '0, pinned: (pin >= 0), duty: '0};
    r.cmd.roll_torque  = 16'(rl);
    r.cmd.pitch_torque = 16'(pt);
    r.cmd.yaw_torque   = 16'(yw);
    r.cmd.total_thrust = 16'(th);
    r.cmd.armed        = armed;
    r.duty             = (pin >= 0) ? 12'(pin) : '0;
    plan.push_back(r);
  endtask

  // Mostly flight-like commands, some raw bit noise, some corner values
  function automatic in_t pick_cmd();
    in_t c;
    int unsigned r;
    logic [95:0] noise;
    r = $urandom_range(99);
    if (r < 65) begin
      c.roll_torque  = 16'($urandom_range(320) - 160);
      c.pitch_torque = 16'($urandom_range(320) - 160);
      c.yaw_torque   = 16'($urandom_range(320) - 160);
      c.total_thrust = 16'($urandom_range(300));
      c.armed        = ($urandom_range(9) != 0);
    end else if (r < 90) begin
      noise = {$urandom(), $urandom(), $urandom()};
      c = noise[$bits(in_t)-1:0];
    end else begin
      c.roll_torque  = 16'(corner_vals[$urandom_range(4)]);
      c.pitch_torque = 16'(corner_vals[$urandom_range(4)]);
      c.yaw_torque   = 16'(corner_vals[$urandom_range(4)]);
      c.total_thrust = 16'(corner_vals[$urandom_range(4)]);
      c.armed        = 1'($urandom_range(1));
    end
    return c;
  endfunction

  // Load a full register setting; junk rides in the unused upper data bits
  task automatic load_setting(input set_kind_e kind);
    logic [CFG_DATA_W-1:0] row;
    logic [CFG_DATA_W-1:0] word;
    int mag;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      case (kind)
        SET_CEIL:  row = {4{16'h7FFF}};
        SET_FLOOR: row = {4{16'h8000}};
        SET_WILD:  row = {$urandom(), $urandom()};
        default: begin
          // X-frame style row: torque weights of either sign, positive thrust
          for (int j = 0; j < NUM_AXES - 1; j++) begin
            mag = $urandom_range(8192);
            row[16*j +: 16] = 16'($urandom_range(1) ? -mag : mag);
          end
          row[63:48] = 16'($urandom_range(8191, 4096));
        end
      endcase
      write_reg(IDX_MIX_ROW_0 + CFG_ADDR_W'(m), row);
    end

    word = {$urandom(), $urandom()};
    case (kind)
      SET_CEIL:  word[BIAS_W-1:0] = 14'(4096);
      SET_FLOOR: word[BIAS_W-1:0] = 14'(-4096);
      SET_WILD:  word[BIAS_W-1:0] = 14'($urandom());
      default:   word[BIAS_W-1:0] = 14'($urandom_range(820) - 410);
    endcase
    write_reg(IDX_THROTTLE_BIAS, word);

    word = {$urandom(), $urandom()};
    case (kind)
      SET_CEIL:  word[NUM_MOTORS*OFF_W-1:0] = '1;
      SET_FLOOR: word[NUM_MOTORS*OFF_W-1:0] = '0;
      default:   ;  // keep the random offsets
    endcase
    write_reg(IDX_MOTOR_OFFSETS, word);

    word = {$urandom(), $urandom()};
    word[0] = (kind == SET_KILL);
    write_reg(IDX_FORCE_DISARM, word);

    // hit the unmapped index too; it must leave the setting alone
    write_reg(IDX_SPARE, {$urandom(), $urandom()});
    settings_run++;
  endtask

  initial begin : stimulus
    set_kind_e kind;
    int unsigned spin;

    // Directed table: reset values first, then each corner of the datapath
    add_cmd(0, 0, 0, 0, 1'b1, 2149);                          // bias 205 only
    add_cmd(32767, 32767, 32767, 32767, 1'b1, 2149);          // zero rows
    add_cmd(-32768, -32768, -32768, -32768, 1'b0, 2047);      // disarmed
    add_write(IDX_FORCE_DISARM, 64'd1);
    add_cmd(0, 0, 0, 256, 1'b1, 2047);                        // forced idle
    add_write(IDX_FORCE_DISARM, 64'd0);
    add_write(IDX_MOTOR_OFFSETS, 64'hF_FFFF_FFFF);
    add_cmd(0, 0, 0, 0, 1'b0, 2558);                          // idle plus max offset
    add_write(IDX_THROTTLE_BIAS, 64'd4096);
    add_cmd(0, 0, 0, 0, 1'b1, 4095);                          // duty saturates
    add_write(IDX_THROTTLE_BIAS, -64'sd4096);
    add_cmd(0, 0, 0, 0, 1'b1, 2558);                          // throttle clamps at 0
    add_write(IDX_MOTOR_OFFSETS, 64'd0);
    add_write(IDX_THROTTLE_BIAS, 64'd206);
    add_write(IDX_MIX_ROW_0, 64'h2000_0000_0000_0000);        // thrust x 1.0
    add_write(IDX_MIX_ROW_1, 64'h0000_0000_0000_E000);        // roll x -1.0
    add_write(IDX_MIX_ROW_2, 64'h7FFF_7FFF_7FFF_7FFF);
    add_write(IDX_MIX_ROW_3, 64'h8000_8000_8000_0001);        // tiny roll weight
    add_write(IDX_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(0, 0, 0, 256, 1'b1, -1);
    add_cmd(-1, 0, 0, 0, 1'b1, -1);                           // floor, not toward zero
    add_cmd(1, 0, 0, 0, 1'b1, -1);
    add_cmd(256, 0, 0, 0, 1'b1, -1);
    add_cmd(-256, 0, 0, 0, 1'b1, -1);
    add_cmd(32767, 32767, 32767, 32767, 1'b1, -1);
    add_cmd(-32768, -32768, -32768, -32768, 1'b1, -1);
    add_cmd(21845, -21846, 21845, -21846, 1'b1, -1);
    add_cmd(-21846, 21845, -21846, 21845, 1'b1, -1);
    add_cmd(100, -100, 50, 128, 1'b1, -1);
    add_cmd(100, -100, 50, 128, 1'b0, -1);

    // Hold reset, then release it on a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the table; settle the pipe before every register write
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain_pipe();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_cmd(plan[i].cmd, plan[i].pinned, plan[i].duty);
      end
    end
    settings_run++;

    // Random phases: extremes first, then disarmed, wild and flight-like rows
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       kind = SET_CEIL;
        1:       kind = SET_FLOOR;
        2:       kind = SET_KILL;
        3:       kind = SET_WILD;
        default: kind = SET_QUAD;
      endcase
      drain_pipe();
      load_setting(kind);
      // one phase runs back to back on both sides
      gap_free   = (p == 4);
      stall_free = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // halfway through the last phase, hold off until the pipe is empty
        if (p == NUM_PHASES - 1 && n == PHASE_ITEMS / 2) begin
          drain_pipe();
        end
        send_cmd(pick_cmd(), 1'b0, '0);
      end
      gap_free   = 1'b0;
      stall_free = 1'b0;
    end
    in_valid_i = 1'b0;

    // Wait for the tail, bounded, then keep watching for stray beats
    spin = 0;
    while (duty_expect.size() != 0 && spin < 10000) begin
      @(negedge clk_i);
      spin++;
    end
    repeat (PIPE_LAT + 4) @(negedge clk_i);
    if (duty_expect.size() != 0) begin
      $error("%0d duty beats never arrived", duty_expect.size());
      fail_count++;
    end

    $display("Run covered %0d command beats over %0d register settings,", cmds_taken,
             settings_run);
    $display("with %0d duty beats compared motor by motor.", duty_checked);
    if (fail_count == 0) begin
      $display("quad_motor_mixer_pwm_top_tb OK");
    end else begin
      $display("quad_motor_mixer_pwm_top_tb NOT OK");
    end
    $finish;
  end

endmodule
